// File: src/fbd_pkg.sv
// Shared types, constants and helpers for the framebuffer draw engine.
package fbd_pkg;

	localparam int MAX_WIDTH_DEF       = 128;
	localparam int MAX_HEIGHT_DEF      = 128;
	localparam int PALETTE_ENTRIES_DEF = 16;

	localparam int COORD_W    = 11;
	localparam int CW         = 11;
	localparam int RC_W       = 14;
	localparam int CFG_W      = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int SIZE_W     = 8;
	localparam int PIDX_W     = 4;
	localparam int PIDX_EXT_W = 9;
	localparam int PIX_W      = 24;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_W-1:0]     CFG_RESET        = 8'd128;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// line math widths
	localparam int FRAC_W  = 16;
	localparam int POS_W   = 29;
	localparam int SQR_W   = 21;
	localparam int L2_W    = 22;
	localparam int DSHIFT  = 2 * (FRAC_W + 1);
	localparam int DIVD_W  = SQR_W + DSHIFT;
	localparam int Q_W     = 35;
	localparam int SQ_W    = 36;
	localparam int SQ_ITER = SQ_W / 2;
	localparam int STEP_W  = 17;
	localparam int N_W     = 11;
	localparam int CNT_W   = 6;

	typedef enum logic [1:0] {
		OP_FILL = 2'd0,
		OP_LINE = 2'd1,
		OP_PAL  = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              rd_invalid;
		logic [CW-1:0]     x0;
		logic [CW-1:0]     y0;
		logic [CW-1:0]     x1;
		logic [CW-1:0]     y1;
		logic [SIZE_W-1:0] size;
		logic [PIDX_W-1:0] idx;
		logic [PIX_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic             start;
		logic [L2_W-1:0]  l2;
		logic [SQR_W-1:0] sqx;
		logic [SQR_W-1:0] sqy;
	} math_req_t;

	typedef struct packed {
		logic              done;
		logic [N_W-1:0]    n;
		logic [STEP_W-1:0] stepx;
		logic [STEP_W-1:0] stepy;
	} math_rsp_t;

	function automatic logic [CW-1:0] clamp_coord(logic signed [RC_W-1:0] v,
		logic [CW-1:0] hi);
		logic signed [RC_W-1:0] hs;
		hs = signed'({{(RC_W-CW){1'b0}}, hi});
		if (v < 0) begin
			return '0;
		end
		if (v > hs) begin
			return hi;
		end
		return v[CW-1:0];
	endfunction

endpackage

// File: src/fbd_queue.sv
// Two-entry request queue between the front and back ends.
module fbd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fbd_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          pop_valid,
	output fbd_pkg::cmd_t pop_data
);

	localparam int DEPTH = fbd_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	fbd_pkg::cmd_t    entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/fbd_front.sv
// Front end: accepts requests, clamps coordinates and classifies reads.
module fbd_front (
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           opcode,
	input  logic signed [fbd_pkg::COORD_W-1:0]   x_start,
	input  logic signed [fbd_pkg::COORD_W-1:0]   y_start,
	input  logic signed [fbd_pkg::COORD_W-1:0]   x_end,
	input  logic signed [fbd_pkg::COORD_W-1:0]   y_end,
	input  logic [fbd_pkg::SIZE_W-1:0]           brush_size,
	input  logic [fbd_pkg::PIDX_W-1:0]           palette_index,
	input  logic [fbd_pkg::PIX_W-1:0]            entry_value,
	input  logic [fbd_pkg::CW-1:0]               w_eff,
	input  logic [fbd_pkg::CW-1:0]               h_eff,
	input  logic                                 q_full,
	output logic                                 q_push,
	output fbd_pkg::cmd_t                        q_data
);

	localparam int EXT = fbd_pkg::RC_W - fbd_pkg::COORD_W;

	logic signed [fbd_pkg::RC_W-1:0] xs_e, ys_e, xe_e, ye_e, w_s, h_s;

	assign xs_e = signed'({{EXT{x_start[fbd_pkg::COORD_W-1]}}, x_start});
	assign ys_e = signed'({{EXT{y_start[fbd_pkg::COORD_W-1]}}, y_start});
	assign xe_e = signed'({{EXT{x_end[fbd_pkg::COORD_W-1]}}, x_end});
	assign ye_e = signed'({{EXT{y_end[fbd_pkg::COORD_W-1]}}, y_end});
	assign w_s  = signed'({{(fbd_pkg::RC_W-fbd_pkg::CW){1'b0}}, w_eff});
	assign h_s  = signed'({{(fbd_pkg::RC_W-fbd_pkg::CW){1'b0}}, h_eff});

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_data            = '0;
		q_data.op         = fbd_pkg::op_t'(opcode);
		q_data.rd_invalid = (xs_e < 0) || (ys_e < 0) || (xs_e >= w_s) || (ys_e >= h_s);
		q_data.x0         = fbd_pkg::clamp_coord(xs_e, w_eff);
		q_data.y0         = fbd_pkg::clamp_coord(ys_e, h_eff);
		q_data.x1         = fbd_pkg::clamp_coord(xe_e, w_eff);
		q_data.y1         = fbd_pkg::clamp_coord(ye_e, h_eff);
		q_data.size       = brush_size;
		q_data.idx        = palette_index;
		q_data.value      = entry_value;
	end

endmodule

// File: src/fbd_line_math.sv
// Iterative line setup: stamp count and direction steps by shared sqrt and divider.
module fbd_line_math (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fbd_pkg::math_req_t    req,
	output fbd_pkg::math_rsp_t    rsp
);

	typedef enum logic [4:0] {
		M_IDLE  = 5'b00001,
		M_SQRTN = 5'b00010,
		M_DIV   = 5'b00100,
		M_SQRTQ = 5'b01000,
		M_DONE  = 5'b10000
	} mstate_t;

	localparam logic [fbd_pkg::SQ_W-1:0] BIT_INIT = fbd_pkg::SQ_W'(1) << (fbd_pkg::SQ_W - 2);

	mstate_t                          state_q;
	logic [fbd_pkg::L2_W-1:0]         l2_q;
	logic [fbd_pkg::SQR_W-1:0]        sqy_q;
	logic                             comp_q;
	logic [fbd_pkg::SQ_W-1:0]         sv_q, sres_q, sbit_q;
	logic [fbd_pkg::CNT_W-1:0]        cnt_q;
	logic [fbd_pkg::L2_W-1:0]         rem_q;
	logic [fbd_pkg::DIVD_W-1:0]       divd_q;
	logic [fbd_pkg::Q_W-1:0]          quo_q;
	logic [fbd_pkg::N_W-1:0]          n_q;
	logic [fbd_pkg::STEP_W-1:0]       stepx_q, stepy_q;

	logic [fbd_pkg::SQ_W-1:0]         s_t, sv_n, sres_n;
	logic                             s_ge;
	logic [fbd_pkg::L2_W:0]           rn;
	logic                             d_ge;
	logic [fbd_pkg::Q_W-1:0]          quo_n;
	logic [fbd_pkg::STEP_W-1:0]       step_n;

	always_comb begin
		s_t    = sres_q + sbit_q;
		s_ge   = (sv_q >= s_t);
		sv_n   = s_ge ? (sv_q - s_t) : sv_q;
		sres_n = s_ge ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);
		rn     = {rem_q, divd_q[fbd_pkg::DIVD_W-1]};
		d_ge   = (rn >= {1'b0, l2_q});
		quo_n  = {quo_q[fbd_pkg::Q_W-2:0], d_ge};
		step_n = fbd_pkg::STEP_W'((sres_n + 1'b1) >> 1);
	end

	assign rsp.done  = (state_q == M_DONE);
	assign rsp.n     = n_q;
	assign rsp.stepx = stepx_q;
	assign rsp.stepy = stepy_q;

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				l2_q   <= req.l2;
				sqy_q  <= req.sqy;
				sv_q   <= fbd_pkg::SQ_W'(req.l2);
				sres_q <= '0;
				sbit_q <= BIT_INIT;
				divd_q <= {req.sqx, {fbd_pkg::DSHIFT{1'b0}}};
			end
			M_SQRTN: begin
				sv_q   <= sv_n;
				sres_q <= sres_n;
				sbit_q <= sbit_q >> 2;
				if (cnt_q == '0) begin
					n_q   <= fbd_pkg::N_W'(sres_n) + fbd_pkg::N_W'(sv_n != '0);
					rem_q <= '0;
					quo_q <= '0;
				end
			end
			M_DIV: begin
				rem_q  <= d_ge ? fbd_pkg::L2_W'(rn - {1'b0, l2_q}) : fbd_pkg::L2_W'(rn);
				quo_q  <= quo_n;
				divd_q <= divd_q << 1;
				if (cnt_q == '0) begin
					sv_q   <= fbd_pkg::SQ_W'(quo_n);
					sres_q <= '0;
					sbit_q <= BIT_INIT;
				end
			end
			M_SQRTQ: begin
				sv_q   <= sv_n;
				sres_q <= sres_n;
				sbit_q <= sbit_q >> 2;
				if (cnt_q == '0) begin
					if (!comp_q) begin
						stepx_q <= step_n;
						divd_q  <= {sqy_q, {fbd_pkg::DSHIFT{1'b0}}};
						rem_q   <= '0;
						quo_q   <= '0;
					end else begin
						stepy_q <= step_n;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			comp_q  <= 1'b0;
		end else begin
			case (state_q)
				M_IDLE: begin
					if (req.start) begin
						state_q <= M_SQRTN;
						cnt_q   <= fbd_pkg::CNT_W'(fbd_pkg::SQ_ITER - 1);
						comp_q  <= 1'b0;
					end
				end
				M_SQRTN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= M_DIV;
						cnt_q   <= fbd_pkg::CNT_W'(fbd_pkg::DIVD_W - 1);
					end
				end
				M_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= M_SQRTQ;
						cnt_q   <= fbd_pkg::CNT_W'(fbd_pkg::SQ_ITER - 1);
					end
				end
				M_SQRTQ: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						if (!comp_q) begin
							state_q <= M_DIV;
							comp_q  <= 1'b1;
							cnt_q   <= fbd_pkg::CNT_W'(fbd_pkg::DIVD_W - 1);
						end else begin
							state_q <= M_DONE;
						end
					end
				end
				M_DONE: begin
					state_q <= M_IDLE;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/fbd_back.sv
// Back end: executes requests against the palette and frame store, holds the result.
module fbd_back #(
	parameter int MAX_WIDTH       = fbd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT      = fbd_pkg::MAX_HEIGHT_DEF,
	parameter int PALETTE_ENTRIES = fbd_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [fbd_pkg::CW-1:0]      w_eff,
	input  logic [fbd_pkg::CW-1:0]      h_eff,
	input  logic                        q_valid,
	input  fbd_pkg::cmd_t               q_data,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fbd_pkg::PIX_W-1:0]   read_pixel,
	output logic                        read_invalid
);

	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int PIW         = $clog2(PALETTE_ENTRIES);
	localparam int CW          = fbd_pkg::CW;
	localparam int RC_W        = fbd_pkg::RC_W;
	localparam int POS_W       = fbd_pkg::POS_W;
	localparam int FRAC_W      = fbd_pkg::FRAC_W;

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_DISP   = 13'b0000000000010,
		S_RSET   = 13'b0000000000100,
		S_RBASE  = 13'b0000000001000,
		S_FILL   = 13'b0000000010000,
		S_LSQ    = 13'b0000000100000,
		S_LSUM   = 13'b0000001000000,
		S_LMATH  = 13'b0000010000000,
		S_LSTAMP = 13'b0000100000000,
		S_LNEXT  = 13'b0001000000000,
		S_RADDR  = 13'b0010000000000,
		S_RWAIT  = 13'b0100000000000,
		S_DONE   = 13'b1000000000000
	} bstate_t;

	bstate_t                         state_q;
	fbd_pkg::cmd_t                   cmd_q;
	logic                            is_line_q;
	logic [fbd_pkg::PIX_W-1:0]       color_q;
	logic [fbd_pkg::PIX_W-1:0]       pal_q [PALETTE_ENTRIES];
	logic [fbd_pkg::PIX_W-1:0]       frame_mem [STORE_DEPTH];
	logic [fbd_pkg::PIX_W-1:0]       rd_data_q;
	logic [AW-1:0]                   raddr_q;
	logic [AW-1:0]                   row_base_q;
	logic signed [RC_W-1:0]          rx0_q, ry0_q, rx1_q, ry1_q;
	logic [CW-1:0]                   fx0_q, fx1_q, fy0_q, fy1_q, fx_q, fy_q;
	logic [fbd_pkg::SQR_W-1:0]       sqx_q, sqy_q;
	logic                            negx_q, negy_q;
	logic signed [POS_W-1:0]         posx_q, posy_q, stepx_q, stepy_q;
	logic [fbd_pkg::N_W-1:0]         n_q, k_q;
	logic                            out_valid_q;
	logic [fbd_pkg::PIX_W-1:0]       out_pixel_q;
	logic                            out_invalid_q;

	logic [fbd_pkg::PIDX_EXT_W-1:0]  idx_ext;
	logic                            idx_ok;
	logic signed [CW:0]              dx, dy;
	logic [CW-1:0]                   ax, ay;
	logic [fbd_pkg::L2_W-1:0]        l2_sum;
	logic [CW-1:0]                   cx0, cx1, cy0, cy1;
	logic [CW-1:0]                   mul_a;
	logic [2*CW-1:0]                 prod;
	logic                            fill_we;
	logic [AW-1:0]                   fill_addr;
	logic                            row_end, rect_end;
	logic signed [RC_W-1:0]          corner_x, corner_y, size_e;
	logic                            out_load;
	bstate_t                         ret_state;
	fbd_pkg::math_req_t              math_req;
	fbd_pkg::math_rsp_t              math_rsp;

	always_comb begin
		idx_ext  = fbd_pkg::PIDX_EXT_W'(cmd_q.idx);
		idx_ok   = (idx_ext < fbd_pkg::PIDX_EXT_W'(PALETTE_ENTRIES));
		dx       = signed'({1'b0, cmd_q.x1}) - signed'({1'b0, cmd_q.x0});
		dy       = signed'({1'b0, cmd_q.y1}) - signed'({1'b0, cmd_q.y0});
		ax       = dx[CW] ? CW'(-dx) : CW'(dx);
		ay       = dy[CW] ? CW'(-dy) : CW'(dy);
		l2_sum   = fbd_pkg::L2_W'(sqx_q) + fbd_pkg::L2_W'(sqy_q);
		cx0      = fbd_pkg::clamp_coord(rx0_q, w_eff);
		cx1      = fbd_pkg::clamp_coord(rx1_q, w_eff);
		cy0      = fbd_pkg::clamp_coord(ry0_q, h_eff);
		cy1      = fbd_pkg::clamp_coord(ry1_q, h_eff);
		mul_a    = (state_q == S_RBASE) ? fy0_q : cmd_q.y0;
		prod     = mul_a * w_eff;
		fill_we  = (state_q == S_FILL);
		fill_addr = row_base_q + AW'(fx_q);
		row_end  = (fx_q + 1'b1 == fx1_q);
		rect_end = row_end && (fy_q + 1'b1 == fy1_q);
		corner_x = RC_W'(signed'(posx_q[POS_W-1:FRAC_W]));
		corner_y = RC_W'(signed'(posy_q[POS_W-1:FRAC_W]));
		size_e   = signed'(RC_W'(cmd_q.size));
		out_load = (state_q == S_DONE) && !out_valid_q;
		ret_state = is_line_q ? S_LNEXT : S_DONE;
	end

	assign math_req.start = (state_q == S_LSUM) && (l2_sum != '0);
	assign math_req.l2    = l2_sum;
	assign math_req.sqx   = sqx_q;
	assign math_req.sqy   = sqy_q;

	fbd_line_math u_math (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (math_req),
		.rsp    (math_rsp)
	);

	assign q_pop        = (state_q == S_IDLE) && q_valid;
	assign out_valid    = out_valid_q;
	assign read_pixel   = out_pixel_q;
	assign read_invalid = out_invalid_q;

	always_ff @(posedge clk) begin
		if (fill_we) begin
			frame_mem[fill_addr] <= color_q;
		end
		rd_data_q <= frame_mem[raddr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PALETTE_ENTRIES; i++) begin
				pal_q[i] <= '0;
			end
		end else if ((state_q == S_DISP) && (cmd_q.op == fbd_pkg::OP_PAL) && idx_ok) begin
			pal_q[idx_ext[PIW-1:0]] <= cmd_q.value;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= q_data;
			end
			S_DISP: begin
				color_q   <= idx_ok ? pal_q[idx_ext[PIW-1:0]] : '0;
				is_line_q <= (cmd_q.op == fbd_pkg::OP_LINE);
				rx0_q     <= signed'(RC_W'(cmd_q.x0));
				ry0_q     <= signed'(RC_W'(cmd_q.y0));
				rx1_q     <= signed'(RC_W'(cmd_q.x1));
				ry1_q     <= signed'(RC_W'(cmd_q.y1));
			end
			S_LSQ: begin
				sqx_q  <= fbd_pkg::SQR_W'(ax * ax);
				sqy_q  <= fbd_pkg::SQR_W'(ay * ay);
				negx_q <= dx[CW];
				negy_q <= dy[CW];
			end
			S_LSUM: begin
				posx_q <= signed'({2'b00, cmd_q.x0, {FRAC_W{1'b0}}});
				posy_q <= signed'({2'b00, cmd_q.y0, {FRAC_W{1'b0}}});
				k_q    <= '0;
			end
			S_LMATH: begin
				n_q     <= math_rsp.n;
				stepx_q <= negx_q ? -signed'(POS_W'(math_rsp.stepx))
					: signed'(POS_W'(math_rsp.stepx));
				stepy_q <= negy_q ? -signed'(POS_W'(math_rsp.stepy))
					: signed'(POS_W'(math_rsp.stepy));
			end
			S_LSTAMP: begin
				rx0_q <= corner_x;
				ry0_q <= corner_y;
				rx1_q <= corner_x + size_e;
				ry1_q <= corner_y + size_e;
			end
			S_LNEXT: begin
				posx_q <= posx_q + stepx_q;
				posy_q <= posy_q + stepy_q;
				k_q    <= k_q + 1'b1;
			end
			S_RSET: begin
				fx0_q <= cx0;
				fx1_q <= cx1;
				fy0_q <= cy0;
				fy1_q <= cy1;
				fx_q  <= cx0;
				fy_q  <= cy0;
			end
			S_RBASE: begin
				row_base_q <= AW'(prod);
			end
			S_FILL: begin
				if (row_end) begin
					fx_q       <= fx0_q;
					fy_q       <= fy_q + 1'b1;
					row_base_q <= row_base_q + AW'(w_eff);
				end else begin
					fx_q <= fx_q + 1'b1;
				end
			end
			S_RADDR: begin
				raddr_q <= AW'(prod + (2*CW)'(cmd_q.x0));
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_invalid_q <= (cmd_q.op == fbd_pkg::OP_READ) && cmd_q.rd_invalid;
			out_pixel_q   <= ((cmd_q.op == fbd_pkg::OP_READ) && !cmd_q.rd_invalid)
				? rd_data_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (cmd_q.op)
						fbd_pkg::OP_FILL: state_q <= S_RSET;
						fbd_pkg::OP_LINE: state_q <= S_LSQ;
						fbd_pkg::OP_READ: state_q <= cmd_q.rd_invalid ? S_DONE : S_RADDR;
						default:          state_q <= S_DONE;
					endcase
				end
				S_LSQ: begin
					state_q <= S_LSUM;
				end
				S_LSUM: begin
					state_q <= (l2_sum == '0) ? S_DONE : S_LMATH;
				end
				S_LMATH: begin
					if (math_rsp.done) begin
						state_q <= S_LSTAMP;
					end
				end
				S_LSTAMP: begin
					state_q <= S_RSET;
				end
				S_RSET: begin
					state_q <= ((cx0 >= cx1) || (cy0 >= cy1)) ? ret_state : S_RBASE;
				end
				S_RBASE: begin
					state_q <= S_FILL;
				end
				S_FILL: begin
					if (rect_end) begin
						state_q <= ret_state;
					end
				end
				S_LNEXT: begin
					state_q <= (k_q + 1'b1 == n_q) ? S_DONE : S_LSTAMP;
				end
				S_RADDR: begin
					state_q <= S_RWAIT;
				end
				S_RWAIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fill_in_rect: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> (fx_q < fx1_q) && (fy_q < fy1_q))
		else $error("fill outside rectangle");
	a_math_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		math_rsp.done |-> (state_q == S_LMATH))
		else $error("line math done outside wait state");
	a_stamp_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LNEXT) |-> (k_q < n_q))
		else $error("stamp counter past stamp count");
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && (state_q == S_IDLE))
		else $error("result not loaded");
`endif

endmodule

// File: src/framebuffer_rect_and_thick_line_draw_core.sv
// Top level of the framebuffer rectangle fill and thick line draw engine.
// A line first computes its stamp count and steps, then fills one square stamp per step; one
// frame store write port sets the fill rate at one pixel per cycle. Requests run one at a time
// in the back end, a two-entry queue accepts up to two more. Reset clears control state, the
// palette to zero and both size registers to 128; the frame store is not cleared.
module framebuffer_rect_and_thick_line_draw_core #(
	parameter int MAX_WIDTH       = fbd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT      = fbd_pkg::MAX_HEIGHT_DEF,
	parameter int PALETTE_ENTRIES = fbd_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [fbd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fbd_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           opcode,
	input  logic signed [fbd_pkg::COORD_W-1:0]   x_start,
	input  logic signed [fbd_pkg::COORD_W-1:0]   y_start,
	input  logic signed [fbd_pkg::COORD_W-1:0]   x_end,
	input  logic signed [fbd_pkg::COORD_W-1:0]   y_end,
	input  logic [fbd_pkg::SIZE_W-1:0]           brush_size,
	input  logic [fbd_pkg::PIDX_W-1:0]           palette_index,
	input  logic [fbd_pkg::PIX_W-1:0]            entry_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [fbd_pkg::PIX_W-1:0]            read_pixel,
	output logic                                 read_invalid
);

	localparam int CW = fbd_pkg::CW;

	logic [fbd_pkg::CFG_W-1:0] frame_width_q, frame_height_q;
	logic [CW-1:0]             w_eff, h_eff;
	logic                      q_full, q_push, q_pop, q_valid;
	fbd_pkg::cmd_t             q_in, q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= fbd_pkg::CFG_RESET;
			frame_height_q <= fbd_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fbd_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				fbd_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = CW'(1);
		end else if (CW'(frame_width_q) > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = CW'(1);
		end else if (CW'(frame_height_q) > CW'(MAX_HEIGHT)) begin
			h_eff = CW'(MAX_HEIGHT);
		end else begin
			h_eff = CW'(frame_height_q);
		end
	end

	fbd_front u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.x_start       (x_start),
		.y_start       (y_start),
		.x_end         (x_end),
		.y_end         (y_end),
		.brush_size    (brush_size),
		.palette_index (palette_index),
		.entry_value   (entry_value),
		.w_eff         (w_eff),
		.h_eff         (h_eff),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (q_in)
	);

	fbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_out)
	);

	fbd_back #(
		.MAX_WIDTH       (MAX_WIDTH),
		.MAX_HEIGHT      (MAX_HEIGHT),
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.w_eff        (w_eff),
		.h_eff        (h_eff),
		.q_valid      (q_valid),
		.q_data       (q_out),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_pixel   (read_pixel),
		.read_invalid (read_invalid)
	);

endmodule
